@@ design/arx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX model package
// Shared widths, command codes, register indexes and the control bundle
// that drives the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package arx_pkg;

  // Table and ring sizes.
  localparam int MAX_ORDER = 8;
  localparam int MAX_DELAY = 16;
  localparam int U_RING    = 32;

  // Field widths fixed by the interface.
  localparam int ORD_W  = 4;
  localparam int DLY_W  = 5;
  localparam int DATA_W = 16;
  localparam int SLOT_W = $clog2(MAX_ORDER);
  localparam int RP_W   = $clog2(U_RING);
  localparam int CNT_W  = $clog2(2 * MAX_ORDER + 1);

  // History memory holds the input ring followed by the output ring.
  localparam int HIST_DEPTH = U_RING + MAX_ORDER;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int COEF_DEPTH = 2 * MAX_ORDER;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  // Product and accumulator widths.
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 5;
  localparam int FRAC_SHIFT = 14;

  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORDER);
  localparam logic [DLY_W-1:0] DLY_MAX = DLY_W'(MAX_DELAY);

  // Item commands.
  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_LOAD_A = 2'd1,
    CMD_LOAD_B = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_ORDER_A     = 2'd0;
  localparam logic [1:0] REG_ORDER_B     = 2'd1;
  localparam logic [1:0] REG_INPUT_DELAY = 2'd2;

  // Control bundle for the multiply-accumulate unit.
  typedef struct packed {
    logic init;  // load the accumulator with the scaled noise sample
    logic term;  // a coefficient and sample pair is present
    logic neg;   // subtract this term (autoregressive part)
  } mac_ctl_t;

endpackage

@@ design/arx_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX multiply-accumulate unit
// Registered product, exact wide accumulator, and rounding with saturation
// of the accumulated sum back to Q8.8.
// ----------------------------------------------------------------------------
module arx_mac import arx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] noise_i,
  input  logic signed [DATA_W-1:0] coeff_i,
  input  logic signed [DATA_W-1:0] samp_i,
  output logic signed [DATA_W-1:0] y_o,
  output logic                     sat_o,
  output logic                     busy_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic                     prod_neg_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-FRAC_SHIFT-1:0] y_wide;

  // Control flags of the product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_neg_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.term;
      prod_neg_q <= ctl_i.neg;
    end
  end

  // Product register, then accumulate.
  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.term) begin
      prod_q <= coeff_i * samp_i;
    end
    if (ctl_i.init) begin
      acc_q <= {{(ACC_W-DATA_W-FRAC_SHIFT){noise_i[DATA_W-1]}}, noise_i, FRAC_SHIFT'(0)};
    end else if (prod_vld_q) begin
      acc_q <= prod_neg_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
  end

  // Round half up, floor by the arithmetic shift, then clip.
  assign acc_rnd = acc_q + ACC_W'(1 << (FRAC_SHIFT - 1));
  assign y_wide  = acc_rnd[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    if (y_wide > (ACC_W-FRAC_SHIFT)'(32767)) begin
      y_o   = DATA_W'(16'h7fff);
      sat_o = 1'b1;
    end else if (y_wide < -(ACC_W-FRAC_SHIFT)'(32768)) begin
      y_o   = DATA_W'(16'h8000);
      sat_o = 1'b1;
    end else begin
      y_o   = y_wide[DATA_W-1:0];
      sat_o = 1'b0;
    end
  end

  assign busy_o = prod_vld_q;

endmodule

@@ design/arx_model_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX plant model step
// Coefficient tables and sample histories live in two synchronous memories;
// one shared multiply-accumulate unit walks the terms of each step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per transfer:
//   a step with u(k) and e(k), a load of an a or b coefficient, or a no-op.
//   A step yields one result on the output channel (out_valid_o /
//   out_ready_i); loads and no-ops yield none and leave the block idle.
//   A step issues one memory read per term, nb + na reads in all; each
//   read passes through the memory read register and the product register
//   into the accumulator, and the rounded sum goes to the output register
//   and to the history when the step retires.
//   The block works on one item at a time; it takes no new item before
//   the step in progress has retired from its last state.
//   The result sits in an output register. A stalled receiver does not stop
//   the next item from being taken; a finished step waits in its last state
//   until the output register is free.
//   Reset sets the orders and delay to 1, ring position to 0, and clears the
//   valid bits of both memories, so every entry reads as zero until written.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
// ----------------------------------------------------------------------------
module arx_model_step import arx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration port
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [DLY_W-1:0]         cfg_data_i,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               command_i,
  input  logic [SLOT_W-1:0]        coeff_index_i,
  input  logic signed [DATA_W-1:0] coeff_value_i,
  input  logic signed [DATA_W-1:0] sample_in_i,
  input  logic signed [DATA_W-1:0] noise_sample_i,
  // Output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] y_out_o,
  output logic                     saturated_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [ORD_W-1:0]   order_a_q, order_b_q;
  logic [DLY_W-1:0]   delay_q;
  logic [ORD_W-1:0]   na_q, nb_q;
  logic [DLY_W-1:0]   dl_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RP_W-1:0]    rp_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  y_out_q;
  logic               sat_q;

  logic               accept, step_acc, load_acc, finish_fire, issue;
  logic [CNT_W-1:0]   total, j;
  logic               is_b_term;

  // Memories and their valid bits.
  logic [DATA_W-1:0]     coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] coef_vld_q;
  logic [DATA_W-1:0]     hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_q;

  logic [COEF_AW-1:0] coef_wa, coef_ra;
  logic [HIST_AW-1:0] hist_wa, hist_ra;
  logic [DATA_W-1:0]  hist_wd;
  logic               hist_we;
  logic [RP_W-1:0]    u_pos;
  logic [SLOT_W-1:0]  y_slot;

  logic [DATA_W-1:0]  coef_rd_q, hist_rd_q;
  logic               coef_rv_q, hist_rv_q;
  logic               rd_vld_q, rd_neg_q;

  mac_ctl_t           mac_ctl;
  logic signed [DATA_W-1:0] mac_coeff, mac_samp, mac_y;
  logic               mac_sat, mac_busy;

  // Handshake decode.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign step_acc    = accept && (command_i == CMD_STEP);
  assign load_acc    = accept && ((command_i == CMD_LOAD_A) || (command_i == CMD_LOAD_B));
  assign finish_fire = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Term walk: b terms first, then a terms.
  assign total     = CNT_W'(nb_q) + CNT_W'(na_q);
  assign issue     = (state_q == ST_RUN) && (cnt_q != total);
  assign is_b_term = cnt_q < CNT_W'(nb_q);
  assign j         = cnt_q - CNT_W'(nb_q);
  assign u_pos     = rp_q - dl_q - cnt_q[RP_W-1:0];
  assign y_slot    = rp_q[SLOT_W-1:0] - SLOT_W'(1) - j[SLOT_W-1:0];

  always_comb begin
    if (is_b_term) begin
      coef_ra = {1'b1, cnt_q[SLOT_W-1:0]};
      hist_ra = HIST_AW'(u_pos);
    end else begin
      coef_ra = {1'b0, j[SLOT_W-1:0]};
      hist_ra = HIST_AW'(U_RING) + HIST_AW'(y_slot);
    end
  end

  // History write: u(k) when a step is taken, y(k) when it retires.
  assign coef_wa = {(command_i == CMD_LOAD_B), coeff_index_i};
  assign hist_we = step_acc || finish_fire;
  assign hist_wa = step_acc ? HIST_AW'(rp_q)
                            : HIST_AW'(U_RING) + HIST_AW'(rp_q[SLOT_W-1:0]);
  assign hist_wd = step_acc ? sample_in_i : mac_y;

  // Memory arrays: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      coef_mem[coef_wa] <= coeff_value_i;
    end
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    coef_rd_q <= coef_mem[coef_ra];
    hist_rd_q <= hist_mem[hist_ra];
  end

  // Valid bits and read pipeline flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      hist_vld_q <= '0;
      coef_rv_q  <= 1'b0;
      hist_rv_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_neg_q   <= 1'b0;
    end else begin
      if (load_acc) begin
        coef_vld_q[coef_wa] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_q[hist_wa] <= 1'b1;
      end
      coef_rv_q <= coef_vld_q[coef_ra];
      hist_rv_q <= hist_vld_q[hist_ra];
      rd_vld_q  <= issue;
      rd_neg_q  <= !is_b_term;
    end
  end

  // Entries never written read as zero.
  assign mac_coeff    = coef_rv_q ? coef_rd_q : '0;
  assign mac_samp     = hist_rv_q ? hist_rd_q : '0;
  assign mac_ctl.init = step_acc;
  assign mac_ctl.term = rd_vld_q;
  assign mac_ctl.neg  = rd_neg_q;

  arx_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .noise_i (noise_sample_i),
    .coeff_i (mac_coeff),
    .samp_i  (mac_samp),
    .y_o     (mac_y),
    .sat_o   (mac_sat),
    .busy_o  (mac_busy)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      order_a_q   <= ORD_W'(1);
      order_b_q   <= ORD_W'(1);
      delay_q     <= DLY_W'(1);
      na_q        <= '0;
      nb_q        <= '0;
      dl_q        <= '0;
      cnt_q       <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
      y_out_q     <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ORDER_A:     order_a_q <= cfg_data_i[ORD_W-1:0];
          REG_ORDER_B:     order_b_q <= cfg_data_i[ORD_W-1:0];
          REG_INPUT_DELAY: delay_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // A result leaving frees the register unless a new one lands now.
      if (out_valid_q && out_ready_i && !finish_fire) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (step_acc) begin
            na_q    <= (order_a_q > ORD_MAX) ? ORD_MAX : order_a_q;
            nb_q    <= (order_b_q > ORD_MAX) ? ORD_MAX : order_b_q;
            dl_q    <= (delay_q > DLY_MAX) ? DLY_MAX : delay_q;
            cnt_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_q && !mac_busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_fire) begin
            out_valid_q <= 1'b1;
            y_out_q     <= mac_y;
            sat_q       <= mac_sat;
            rp_q        <= rp_q + RP_W'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_out_o     = y_out_q;
  assign saturated_o = sat_q;

endmodule
